### src/aabb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_pkg: shared types and constants of the box-pair broad phase
// Sizes of the box store and index fields, the box and result records,
// the sequencer states and the three-axis overlap test.
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);
  localparam int OUT_IDX_W = 6;
  localparam int COORD_W   = 32;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  typedef struct packed {
    logic is_dynamic;
    box_t box;
  } entry_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] earlier_index;
    logic [OUT_IDX_W-1:0] later_index;
    logic                 overflow;
    logic                 last_of_run;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_OVF
  } state_t;

  // touching faces count as overlap
  function automatic logic box_overlap(box_t a, box_t b);
    logic ox;
    logic oy;
    logic oz;
    ox = !((a.max_x < b.min_x) || (a.min_x > b.max_x));
    oy = !((a.max_y < b.min_y) || (a.min_y > b.max_y));
    oz = !((a.max_z < b.min_z) || (a.min_z > b.max_z));
    return ox && oy && oz;
  endfunction

endpackage

### src/aabb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_if: channel interfaces of the box-pair broad phase
// Input channel carries one box per beat; output channel one pair result.
// ----------------------------------------------------------------------------
interface aabb_in_if import aabb_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   frame_start;
  logic   is_dynamic;
  coord_t min_x;
  coord_t min_y;
  coord_t min_z;
  coord_t max_x;
  coord_t max_y;
  coord_t max_z;

  modport source (
    output valid, frame_start, is_dynamic, min_x, min_y, min_z, max_x, max_y, max_z,
    input  ready
  );
  modport sink (
    input  valid, frame_start, is_dynamic, min_x, min_y, min_z, max_x, max_y, max_z,
    output ready
  );
endinterface

interface aabb_out_if import aabb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] earlier_index;
  logic [OUT_IDX_W-1:0] later_index;
  logic                 overflow;
  logic                 last_of_run;

  modport source (
    output valid, earlier_index, later_index, overflow, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, earlier_index, later_index, overflow, last_of_run,
    output ready
  );
endinterface

### src/aabb_pair_broad_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_pair_broad_phase: brute-force box-pair broad phase
// One box per input beat on in_ch. A frame_start beat empties the store and
// takes index 0; each later box takes the next index and is stored. A dynamic
// box is tested against every earlier dynamic box of the frame, one stored
// entry per cycle unless stalled, from a single-port box memory through one
// overlap unit. Each overlapping pair leaves on out_ch as (earlier, later),
// earlier index rising, with last_of_run on the final pair of the box. A box
// beyond the store capacity is dropped and gives one overflow beat.
// in_ch.ready is high only while the sequencer is idle. A dynamic box with
// an earlier entry in the frame holds the block for its scan and for its last
// pair; a static box, or the first of a frame, is stored without a scan. The
// memory read and compare form a two-stage loop that stalls when a found pair
// meets a pair already pending and a full output register.
// out_ch is driven from a register; a stalled receiver holds the beat and,
// once a second pair is found, the scan. Reset empties the store count and
// drops any beat in flight; store contents need no clearing.
// ----------------------------------------------------------------------------
module aabb_pair_broad_phase import aabb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  aabb_in_if.sink    in_ch,
  aabb_out_if.source out_ch
);

  state_t           state_r,    state_nxt;
  logic [CNT_W-1:0] count_r,    count_nxt;
  logic             out_vld_r,  out_vld_nxt;
  logic             cmp_vld_r,  cmp_vld_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  result_t          out_data_r, out_data_nxt;
  box_t             new_r,      new_nxt;
  logic [IDX_W-1:0] new_idx_r,  new_idx_nxt;
  logic [IDX_W-1:0] addr_r,     addr_nxt;
  logic [IDX_W-1:0] cmp_idx_r,  cmp_idx_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;

  entry_t           store_r [MAX_BOXES];
  entry_t           rdata_r;
  entry_t           wdata;

  logic [CNT_W-1:0] count_eff;
  logic             mem_we;
  logic             rd_en;
  logic             in_ready;
  logic             issuing;
  logic             hit;
  logic             out_free;
  logic             stall;

  assign count_eff = in_ch.frame_start ? '0 : count_r;
  assign issuing   = (addr_r != new_idx_r);
  assign hit       = cmp_vld_r && rdata_r.is_dynamic && box_overlap(rdata_r.box, new_r);
  assign out_free  = !out_vld_r || out_ch.ready;
  assign stall     = hit && pend_vld_r && !out_free;

  assign wdata.is_dynamic = in_ch.is_dynamic;
  assign wdata.box        = new_nxt;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_data_nxt = out_data_r;
    cmp_vld_nxt  = cmp_vld_r;
    pend_vld_nxt = pend_vld_r;
    new_idx_nxt  = new_idx_r;
    addr_nxt     = addr_r;
    cmp_idx_nxt  = cmp_idx_r;
    pend_idx_nxt = pend_idx_r;
    new_nxt.min_x = in_ch.min_x;
    new_nxt.min_y = in_ch.min_y;
    new_nxt.min_z = in_ch.min_z;
    new_nxt.max_x = in_ch.max_x;
    new_nxt.max_y = in_ch.max_y;
    new_nxt.max_z = in_ch.max_z;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          if (count_eff == CNT_W'(MAX_BOXES)) begin
            count_nxt = count_eff;
            state_nxt = ST_OVF;
          end else begin
            mem_we       = 1'b1;
            count_nxt    = count_eff + 1'b1;
            new_idx_nxt  = count_eff[IDX_W-1:0];
            addr_nxt     = '0;
            cmp_vld_nxt  = 1'b0;
            pend_vld_nxt = 1'b0;
            if (in_ch.is_dynamic && (count_eff != '0)) begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          rd_en       = 1'b1;
          cmp_vld_nxt = issuing;
          cmp_idx_nxt = addr_r;
          if (issuing) begin
            addr_nxt = addr_r + 1'b1;
          end
          if (hit) begin
            if (pend_vld_r) begin
              out_vld_nxt                = 1'b1;
              out_data_nxt.earlier_index = OUT_IDX_W'(pend_idx_r);
              out_data_nxt.later_index   = OUT_IDX_W'(new_idx_r);
              out_data_nxt.overflow      = 1'b0;
              out_data_nxt.last_of_run   = 1'b0;
            end
            pend_idx_nxt = cmp_idx_r;
            pend_vld_nxt = 1'b1;
          end
          if (!issuing) begin
            state_nxt = pend_vld_nxt ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_vld_nxt                = 1'b1;
          out_data_nxt.earlier_index = OUT_IDX_W'(pend_idx_r);
          out_data_nxt.later_index   = OUT_IDX_W'(new_idx_r);
          out_data_nxt.overflow      = 1'b0;
          out_data_nxt.last_of_run   = 1'b1;
          pend_vld_nxt               = 1'b0;
          state_nxt                  = ST_IDLE;
        end
      end
      ST_OVF: begin
        if (out_free) begin
          out_vld_nxt                = 1'b1;
          out_data_nxt.earlier_index = '0;
          out_data_nxt.later_index   = '0;
          out_data_nxt.overflow      = 1'b1;
          out_data_nxt.last_of_run   = 1'b1;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      out_vld_r  <= 1'b0;
      cmp_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      out_vld_r  <= out_vld_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    new_idx_r  <= new_idx_nxt;
    addr_r     <= addr_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (mem_we) begin
      new_r <= new_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[count_eff[IDX_W-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= store_r[addr_r];
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_vld_r;
  assign out_ch.earlier_index = out_data_r.earlier_index;
  assign out_ch.later_index   = out_data_r.later_index;
  assign out_ch.overflow      = out_data_r.overflow;
  assign out_ch.last_of_run   = out_data_r.last_of_run;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BOXES))
    else $error("store count beyond capacity");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_vld_r)
    else $error("pending pair left behind at idle");

  a_scan_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (addr_r <= new_idx_r) && (new_idx_r != '0))
    else $error("scan address past the new box");

  a_ovf_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.overflow) |->
      (out_data_r.last_of_run && (out_data_r.earlier_index == '0) &&
       (out_data_r.later_index == '0)))
    else $error("overflow beat with nonzero indices");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_data_r.overflow) |->
      (out_data_r.earlier_index < out_data_r.later_index))
    else $error("pair indices out of order");
`endif

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: box-pair broad phase
// Feeds frames of boxes into the block and checks each pair and overflow beat
// against a behavioural model of the store and overlap test. The run has a
// short directed part and then random frames: small frames, tightly clustered
// full frames that run into capacity, noise boxes and inverted boxes. Both
// sides idle in random bursts, and the receiver holds off for one long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import aabb_pkg::*;

  localparam int     UNIT         = 65536;
  localparam int     ITEM_TARGET  = 370;
  localparam int     TAIL_ITEMS   = 40;
  localparam int     LONG_HOLD    = 400;
  localparam int     QUIET_LIMIT  = 2000;
  localparam int     DRAIN_CYCLES = 2 * MAX_BOXES + 10;
  localparam int     PRINT_CAP    = 40;
  localparam coord_t C_MIN        = 32'sh8000_0000;
  localparam coord_t C_MAX        = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic frame_start;
    logic is_dynamic;
    box_t box;
  } box_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  aabb_in_if  in_ch ();
  aabb_out_if out_ch ();

  aabb_pair_broad_phase u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  box_beat_t box_queue [$];
  result_t   expected_pairs [$];
  box_beat_t cur_beat;

  box_t frame_boxes [MAX_BOXES];
  logic frame_dyn   [MAX_BOXES];
  int   frame_fill;

  int   total_boxes;
  int   boxes_taken;
  int   frames_seen;
  int   longest_run;
  int   pairs_seen;
  int   overflows_seen;
  int   errors;
  int   gap_left;
  int   stall_left;
  int   quiet_cycles;
  logic tail_phase;
  logic hold_off;

  task automatic report(input string what);
    errors++;
    if (errors <= PRINT_CAP)
      $display("[%0t] MISMATCH %s", $time, what);
  endtask

  function automatic logic spans_meet(coord_t a_lo, coord_t a_hi, coord_t b_lo, coord_t b_hi);
    return !(a_hi < b_lo || a_lo > b_hi);
  endfunction

  function automatic logic boxes_meet(box_t a, box_t b);
    return spans_meet(a.min_x, a.max_x, b.min_x, b.max_x) &&
           spans_meet(a.min_y, a.max_y, b.min_y, b.max_y) &&
           spans_meet(a.min_z, a.max_z, b.min_z, b.max_z);
  endfunction

  task automatic predict_pairs(input box_beat_t beat);
    int      hits [$];
    result_t r;
    if (beat.frame_start) begin
      frame_fill = 0;
      frames_seen++;
    end
    if (frame_fill >= MAX_BOXES) begin
      r = '{earlier_index: '0, later_index: '0, overflow: 1'b1, last_of_run: 1'b1};
      expected_pairs.insert(expected_pairs.size(), r);
      return;
    end
    if (beat.is_dynamic) begin
      for (int j = 0; j < frame_fill; j++) begin
        if (frame_dyn[j] && boxes_meet(frame_boxes[j], beat.box))
          hits.insert(hits.size(), j);
      end
    end
    foreach (hits[k]) begin
      r.earlier_index = OUT_IDX_W'(hits[k]);
      r.later_index   = OUT_IDX_W'(frame_fill);
      r.overflow      = 1'b0;
      r.last_of_run   = (k == hits.size() - 1);
      expected_pairs.insert(expected_pairs.size(), r);
    end
    if (hits.size() > longest_run)
      longest_run = hits.size();
    frame_boxes[frame_fill] = beat.box;
    frame_dyn[frame_fill]   = beat.is_dynamic;
    frame_fill++;
  endtask

  function automatic box_t cube(coord_t lo, coord_t hi);
    box_t b;
    b.min_x = lo;
    b.min_y = lo;
    b.min_z = lo;
    b.max_x = hi;
    b.max_y = hi;
    b.max_z = hi;
    return b;
  endfunction

  function automatic box_t random_box(int spread, bit clean);
    box_t   b;
    coord_t lo [3];
    coord_t hi [3];
    coord_t t;
    int     pick;
    int     ax;
    pick = clean ? 2 : $urandom_range(0, 15);
    for (int a = 0; a < 3; a++) begin
      lo[a] = coord_t'((int'($urandom_range(0, 2 * spread)) - spread) * UNIT +
                       int'($urandom_range(0, UNIT - 1)));
      hi[a] = lo[a] + coord_t'(int'($urandom_range(1, 8)) * UNIT +
                               int'($urandom_range(0, UNIT - 1)));
    end
    if (pick == 1) begin
      ax     = $urandom_range(0, 2);
      t      = lo[ax];
      lo[ax] = hi[ax];
      hi[ax] = t;
    end
    b.min_x = lo[0];
    b.min_y = lo[1];
    b.min_z = lo[2];
    b.max_x = hi[0];
    b.max_y = hi[1];
    b.max_z = hi[2];
    if (pick == 0)
      b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return b;
  endfunction

  task automatic add_box(input logic fs, input logic dyn, input box_t b);
    box_beat_t beat;
    beat.frame_start = fs;
    beat.is_dynamic  = dyn;
    beat.box         = b;
    box_queue.insert(box_queue.size(), beat);
  endtask

  task automatic load_boxes();
    box_t b;
    int   frame_no;
    int   frame_len;
    int   spread;
    int   dyn_pct;
    bit   clean;
    // extremes, touching faces, a near miss, an inverted box, static entries
    add_box(1'b0, 1'b1, cube(C_MIN, C_MAX));
    add_box(1'b0, 1'b1, cube(C_MAX, C_MAX));
    add_box(1'b0, 1'b1, cube(C_MIN, C_MIN));
    add_box(1'b0, 1'b0, cube(C_MIN, C_MAX));
    add_box(1'b0, 1'b1, cube(0, 10 * UNIT));
    b       = cube(0, 10 * UNIT);
    b.min_x = 10 * UNIT;
    b.max_x = 20 * UNIT;
    add_box(1'b0, 1'b1, b);
    b.min_x = 10 * UNIT + 1;
    add_box(1'b0, 1'b1, b);
    b       = cube(0, 10 * UNIT);
    b.min_x = 20 * UNIT;
    b.max_x = 0;
    add_box(1'b0, 1'b1, b);
    add_box(1'b0, 1'b1, cube(1000 * UNIT, 1001 * UNIT));
    add_box(1'b1, 1'b1, cube(0, UNIT));
    add_box(1'b0, 1'b1, cube(5 * UNIT, 6 * UNIT));
    add_box(1'b0, 1'b0, cube(0, 6 * UNIT));
    add_box(1'b0, 1'b1, cube(0, 6 * UNIT));
    add_box(1'b1, 1'b0, cube(0, UNIT));
    add_box(1'b1, 1'b1, cube(0, UNIT));
    add_box(1'b0, 1'b1, cube(0, UNIT));
    add_box(1'b0, 1'b1, cube(-3 * UNIT, 0));

    frame_no = 0;
    while (box_queue.size() < ITEM_TARGET) begin
      if (frame_no == 1 || frame_no == 5) begin
        frame_len = MAX_BOXES + $urandom_range(2, 5);
        clean     = (frame_no == 1);
        spread    = clean ? 0 : 12;
        dyn_pct   = clean ? 100 : 70;
      end else begin
        frame_len = $urandom_range(1, 24);
        clean     = 1'b0;
        spread    = $urandom_range(1, 20);
        dyn_pct   = $urandom_range(40, 100);
      end
      for (int k = 0; k < frame_len; k++)
        add_box(k == 0, $urandom_range(1, 100) <= dyn_pct, random_box(spread, clean));
      frame_no++;
    end
    total_boxes = box_queue.size();
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left     = 0;
      tail_phase  <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_pairs(cur_beat);
        boxes_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
          gap_left     = $urandom_range(1, 18) - 1;
          in_ch.valid <= 1'b0;
        end else if (box_queue.size() > 0) begin
          cur_beat           = box_queue.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.frame_start <= cur_beat.frame_start;
          in_ch.is_dynamic  <= cur_beat.is_dynamic;
          in_ch.min_x       <= cur_beat.box.min_x;
          in_ch.min_y       <= cur_beat.box.min_y;
          in_ch.min_z       <= cur_beat.box.min_z;
          in_ch.max_x       <= cur_beat.box.max_x;
          in_ch.max_y       <= cur_beat.box.max_y;
          in_ch.max_z       <= cur_beat.box.max_z;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      tail_phase <= (box_queue.size() < TAIL_ITEMS);
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left    = 0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!tail_phase && $urandom_range(0, 11) == 0) begin
      stall_left    = $urandom_range(1, 18) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // hold the receiver off long enough for the block to back up
  initial begin
    hold_off = 1'b0;
    while (boxes_taken < 30)
      @(posedge clk);
    hold_off <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic check_field(input string name, input logic [OUT_IDX_W-1:0] got,
                             input logic [OUT_IDX_W-1:0] want);
    if (got !== want)
      report($sformatf("beat %0d %s got %0d want %0d", pairs_seen + overflows_seen,
                       name, got, want));
  endtask

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pairs.size() == 0) begin
        report($sformatf("beat (%0d,%0d) ovf %0b with nothing pending",
                         out_ch.earlier_index, out_ch.later_index, out_ch.overflow));
      end else begin
        want = expected_pairs.pop_front();
        check_field("earlier_index", out_ch.earlier_index, want.earlier_index);
        check_field("later_index", out_ch.later_index, want.later_index);
        check_field("overflow", OUT_IDX_W'(out_ch.overflow), OUT_IDX_W'(want.overflow));
        check_field("last_of_run", OUT_IDX_W'(out_ch.last_of_run),
                    OUT_IDX_W'(want.last_of_run));
      end
      if (out_ch.overflow)
        overflows_seen++;
      else
        pairs_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[%0t] no beat for %0d cycles, %0d boxes taken, %0d results pending",
             $time, QUIET_LIMIT, boxes_taken, expected_pairs.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.frame_start = 1'b0;
    in_ch.is_dynamic  = 1'b0;
    in_ch.min_x       = '0;
    in_ch.min_y       = '0;
    in_ch.min_z       = '0;
    in_ch.max_x       = '0;
    in_ch.max_y       = '0;
    in_ch.max_z       = '0;
    out_ch.ready      = 1'b0;
    frame_fill        = 0;
    boxes_taken       = 0;
    frames_seen       = 0;
    longest_run       = 0;
    pairs_seen        = 0;
    overflows_seen    = 0;
    errors            = 0;
    quiet_cycles      = 0;
    load_boxes();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (boxes_taken < total_boxes)
      @(posedge clk);
    while (expected_pairs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d boxes in %0d frames; checked %0d pairs and %0d overflow beats",
             total_boxes, frames_seen, pairs_seen, overflows_seen);
    $display("Most pairs from one box: %0d; mismatches: %0d", longest_run, errors);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
